@@ hdl/formal_concept_next_closure_macros.svh @@
// Assertion macros for the concept enumeration block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef FORMAL_CONCEPT_NEXT_CLOSURE_MACROS_SVH
`define FORMAL_CONCEPT_NEXT_CLOSURE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define FCNC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concept enumeration check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concept enumeration check failed");

`else

`define FCNC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FCNC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/fcnc_pkg.sv @@
package fcnc_pkg;

    localparam int NUM_ATTRS_DEF = 30;
    localparam int FIELD_W       = 30;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_FAILED   = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] body_mask;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] extent_set;
        logic [FIELD_W-1:0] intent_set;
        logic               is_last;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic clear;
        logic add;
    } tbl_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CLOSE,
        S_INTENT,
        S_EMIT
    } state_t;

endpackage

@@ hdl/fcnc_table.sv @@
module fcnc_table #(
    parameter int NUM_ATTRS = fcnc_pkg::NUM_ATTRS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fcnc_pkg::tbl_ctrl_t                 ctrl,
    input  logic [NUM_ATTRS-1:0]                body,
    output logic [NUM_ATTRS-1:0][NUM_ATTRS-1:0] rows
);

    logic [NUM_ATTRS-1:0][NUM_ATTRS-1:0] rows_reg;

    // Each body is merged into the row of every attribute it holds.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            rows_reg <= '0;
        end else if (ctrl.add) begin
            for (int k = 0; k < NUM_ATTRS; k++) begin
                if (body[k]) begin
                    rows_reg[k] <= rows_reg[k] | body;
                end
            end
        end
    end

    assign rows = rows_reg;

endmodule

@@ hdl/fcnc_derive.sv @@
module fcnc_derive #(
    parameter int NUM_ATTRS = fcnc_pkg::NUM_ATTRS_DEF
) (
    input  logic [NUM_ATTRS-1:0]                set_in,
    input  logic [NUM_ATTRS-1:0][NUM_ATTRS-1:0] rows,
    output logic [NUM_ATTRS-1:0]                derived
);

    // A result bit survives unless some selected attribute cooccurs with it,
    // which is the AND of the inverted relation rows of the selected attributes.
    always_comb begin
        for (int j = 0; j < NUM_ATTRS; j++) begin
            derived[j] = 1'b1;
            for (int k = 0; k < NUM_ATTRS; k++) begin
                derived[j] = derived[j] & ~(set_in[k] & rows[k][j]);
            end
        end
    end

endmodule

@@ hdl/formal_concept_next_closure.sv @@
// Each advance is worked out step by step by the single shared derivation unit,
// which is used twice per attribute position tried.
// Clear and add keep input ready high; a next command holds input ready low
// until its result is registered, and that waits while the output register
// still holds a result that has not been taken.
// Reset (aresetn low, synchronous) empties the table and restarts the enumeration.
module formal_concept_next_closure #(
    parameter int NUM_ATTRS = fcnc_pkg::NUM_ATTRS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fcnc_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output fcnc_pkg::out_t  m_data
);

    `include "formal_concept_next_closure_macros.svh"

    localparam int IW = $clog2(NUM_ATTRS);
    localparam int FW = fcnc_pkg::FIELD_W;

    // Control state.
    fcnc_pkg::state_t state_reg, state_next;
    logic             started_reg, started_next;
    logic             finished_reg, finished_next;
    logic [NUM_ATTRS-1:0] cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;

    // Working registers of the sequencer.
    logic             init_reg, init_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [NUM_ATTRS-1:0] t_reg, t_next;
    logic [NUM_ATTRS-1:0] a_reg, a_next;
    fcnc_pkg::out_t   pend_reg, pend_next;
    fcnc_pkg::out_t   out_reg, out_next;

    // Table and shared derivation unit.
    fcnc_pkg::tbl_ctrl_t                 tbl_ctrl;
    logic [NUM_ATTRS-1:0]                body_n;
    logic [NUM_ATTRS+FW-1:0]             body_wide;
    logic [NUM_ATTRS-1:0][NUM_ATTRS-1:0] rows;
    logic [NUM_ATTRS-1:0]                der_in;
    logic [NUM_ATTRS-1:0]                der_out;

    // Position masks for the attribute currently being tried.
    logic [NUM_ATTRS-1:0] bit_mask;
    logic [NUM_ATTRS-1:0] below_mask;
    logic [NUM_ATTRS-1:0] prefix;
    logic                 cand_ok;
    logic [FW+NUM_ATTRS-1:0] ext_wide;
    logic [FW+NUM_ATTRS-1:0] int_wide;

    logic accept;

    // Conditions watched by the checks at the end.
    logic next_after_end;
    logic emit_finished;
    logic emit_failed;
    logic in_close;
    logic probe_free;

    assign s_ready = (state_reg == fcnc_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Body bits beyond the attribute count are dropped; missing ones are zero.
    assign body_wide = {{NUM_ATTRS{1'b0}}, s_data.body_mask};
    assign body_n    = body_wide[NUM_ATTRS-1:0];

    always_comb begin
        for (int j = 0; j < NUM_ATTRS; j++) begin
            bit_mask[j]   = (j == int'(idx_reg));
            below_mask[j] = (j < int'(idx_reg));
        end
    end

    assign prefix = cur_reg & below_mask;

    // The shared unit derives from the probe set, then from the intermediate set,
    // then from the accepted extent, depending on the step.
    always_comb begin
        case (state_reg)
            fcnc_pkg::S_PROBE: der_in = init_reg ? '0 : (prefix | bit_mask);
            fcnc_pkg::S_CLOSE: der_in = t_reg;
            default:           der_in = a_reg;
        endcase
    end

    // Lectic test: the closure must not add anything below the tried position.
    assign cand_ok = init_reg || ((der_out & below_mask) == prefix);

    fcnc_table #(
        .NUM_ATTRS(NUM_ATTRS)
    ) u_table (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (tbl_ctrl),
        .body   (body_n),
        .rows   (rows)
    );

    fcnc_derive #(
        .NUM_ATTRS(NUM_ATTRS)
    ) u_derive (
        .set_in (der_in),
        .rows   (rows),
        .derived(der_out)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcnc_pkg::S_IDLE: begin
                if (accept && s_data.cmd == fcnc_pkg::CMD_NEXT) begin
                    state_next = finished_reg ? fcnc_pkg::S_EMIT : fcnc_pkg::S_PROBE;
                end
            end
            fcnc_pkg::S_PROBE: begin
                if (init_reg || !cur_reg[idx_reg]) begin
                    state_next = fcnc_pkg::S_CLOSE;
                end else if (idx_reg == '0) begin
                    state_next = fcnc_pkg::S_EMIT;
                end
            end
            fcnc_pkg::S_CLOSE: begin
                if (cand_ok) begin
                    state_next = fcnc_pkg::S_INTENT;
                end else if (idx_reg == '0) begin
                    state_next = fcnc_pkg::S_EMIT;
                end else begin
                    state_next = fcnc_pkg::S_PROBE;
                end
            end
            fcnc_pkg::S_INTENT: state_next = fcnc_pkg::S_EMIT;
            fcnc_pkg::S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = fcnc_pkg::S_IDLE;
                end
            end
            default: state_next = fcnc_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        started_next  = started_reg;
        finished_next = finished_reg;
        cur_next      = cur_reg;
        init_next     = init_reg;
        idx_next      = idx_reg;
        t_next        = t_reg;
        a_next        = a_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        tbl_ctrl      = '0;
        ext_wide      = {{FW{1'b0}}, a_reg};
        int_wide      = {{FW{1'b0}}, der_out};

        // The output register drains independently of the sequencer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fcnc_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_data.cmd)
                        fcnc_pkg::CMD_CLEAR: begin
                            tbl_ctrl.clear = 1'b1;
                            started_next   = 1'b0;
                            finished_next  = 1'b0;
                            cur_next       = '0;
                        end
                        fcnc_pkg::CMD_ADD: begin
                            tbl_ctrl.add = 1'b1;
                        end
                        fcnc_pkg::CMD_NEXT: begin
                            init_next = !started_reg;
                            idx_next  = IW'(NUM_ATTRS - 1);
                            pend_next = '0;
                            if (finished_reg) begin
                                pend_next.status = fcnc_pkg::ST_FINISHED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fcnc_pkg::S_PROBE: begin
                if (init_reg || !cur_reg[idx_reg]) begin
                    t_next = der_out;
                end else if (idx_reg == '0) begin
                    finished_next    = 1'b1;
                    pend_next        = '0;
                    pend_next.status = fcnc_pkg::ST_FAILED;
                end else begin
                    idx_next = idx_reg - IW'(1);
                end
            end
            fcnc_pkg::S_CLOSE: begin
                if (cand_ok) begin
                    a_next = der_out;
                end else if (idx_reg == '0) begin
                    finished_next    = 1'b1;
                    pend_next        = '0;
                    pend_next.status = fcnc_pkg::ST_FAILED;
                end else begin
                    idx_next = idx_reg - IW'(1);
                end
            end
            fcnc_pkg::S_INTENT: begin
                cur_next             = a_reg;
                started_next         = 1'b1;
                pend_next.extent_set = ext_wide[FW-1:0];
                pend_next.intent_set = int_wide[FW-1:0];
                pend_next.is_last    = (a_reg == '1);
                pend_next.status     = fcnc_pkg::ST_VALID;
                if (a_reg == '1) begin
                    finished_next = 1'b1;
                end
            end
            fcnc_pkg::S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = pend_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fcnc_pkg::S_IDLE;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            cur_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            cur_reg      <= cur_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        init_reg <= init_next;
        idx_reg  <= idx_next;
        t_reg    <= t_next;
        a_reg    <= a_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign next_after_end = accept && s_data.cmd == fcnc_pkg::CMD_NEXT && finished_reg;
    assign emit_finished  = state_reg == fcnc_pkg::S_EMIT
                            && pend_reg.status == fcnc_pkg::ST_FINISHED;
    assign emit_failed    = state_reg == fcnc_pkg::S_EMIT
                            && pend_reg.status == fcnc_pkg::ST_FAILED;
    assign in_close       = state_reg == fcnc_pkg::S_CLOSE;
    assign probe_free     = init_reg || !cur_reg[idx_reg];

    // A next command after the end goes straight to the emit step with status finished.
    `FCNC_ASSERT_NEXT(a_done_emit, aclk, aresetn, next_after_end, emit_finished)
    // A failed advance always leaves the enumeration marked as finished.
    `FCNC_ASSERT_SAME(a_fail_done, aclk, aresetn, emit_failed, finished_reg)
    // Only positions absent from the current extent are ever closed.
    `FCNC_ASSERT_SAME(a_probe_free, aclk, aresetn, in_close, probe_free)

endmodule
